// ===== rtl/core/dmm_pkg.sv =====
// Package for the density matrix mixer: widths, fixed-point constants,
// configuration register indexes, reset values and the payload structs.
// No dependencies.
package dmm_pkg;

    // Fixed-point format of densities and coefficients
    localparam int FRAC_BITS = 12;
    localparam int DATA_W    = 16;
    localparam int ROW_W     = 3 * DATA_W;
    localparam int TOL_W     = 12;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int ACC_W     = PROD_W + 3;
    localparam int DIFF_W    = DATA_W + 2;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = ROW_W;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_RED   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_GREEN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_BLUE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 3'd3;

    // 1.0 in Q3.12 and the register reset values built from it
    localparam logic [DATA_W-1:0] UNITY         = DATA_W'(1 << FRAC_BITS);
    localparam logic [ROW_W-1:0]  ROW_RED_RST   = ROW_W'(UNITY);
    localparam logic [ROW_W-1:0]  ROW_GREEN_RST = ROW_W'(UNITY) << DATA_W;
    localparam logic [ROW_W-1:0]  ROW_BLUE_RST  = ROW_W'(UNITY) << (2 * DATA_W);
    localparam logic [TOL_W-1:0]  TOL_RST       = TOL_W'(4);

    // Rounding and saturation constants of the mixed sum
    localparam logic signed [ACC_W-1:0]  ROUND_HALF = ACC_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0]  SAT_LIMIT  = ACC_W'(32767);
    localparam logic [DATA_W-1:0]        SAT_MAX    = DATA_W'(32767);

    typedef struct packed {
        logic signed [DATA_W-1:0] density_red;
        logic signed [DATA_W-1:0] density_green;
        logic signed [DATA_W-1:0] density_blue;
    } pix_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] out_red;
        logic signed [DATA_W-1:0] out_green;
        logic signed [DATA_W-1:0] out_blue;
    } pix_out_t;

    // Coefficient rows and the identity verdict, from the register file
    typedef struct packed {
        logic [ROW_W-1:0] row_red;
        logic [ROW_W-1:0] row_green;
        logic [ROW_W-1:0] row_blue;
        logic             bypass;
    } mix_cfg_t;

endpackage

// ===== rtl/core/dmm_cfg_regs.sv =====
// Configuration registers of the density matrix mixer and the identity test.
// Depends on dmm_pkg.
module dmm_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [dmm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dmm_pkg::CFG_DATA_W-1:0]   cfg_data,
    output dmm_pkg::mix_cfg_t                cfg
);

    logic [dmm_pkg::ROW_W-1:0] row_red_reg, row_red_next;
    logic [dmm_pkg::ROW_W-1:0] row_green_reg, row_green_next;
    logic [dmm_pkg::ROW_W-1:0] row_blue_reg, row_blue_next;
    logic [dmm_pkg::TOL_W-1:0] tol_reg, tol_next;
    logic [dmm_pkg::ROW_W-1:0] rows [3];
    logic                      ident;

    // Decode the register write; drop unknown indexes
    always_comb
    begin
        row_red_next   = row_red_reg;
        row_green_next = row_green_reg;
        row_blue_next  = row_blue_reg;
        tol_next       = tol_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                dmm_pkg::CFG_ROW_RED:   row_red_next   = cfg_data;
                dmm_pkg::CFG_ROW_GREEN: row_green_next = cfg_data;
                dmm_pkg::CFG_ROW_BLUE:  row_blue_next  = cfg_data;
                dmm_pkg::CFG_TOLERANCE: tol_next       = cfg_data[dmm_pkg::TOL_W-1:0];
                default:                ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_red_reg   <= dmm_pkg::ROW_RED_RST;
            row_green_reg <= dmm_pkg::ROW_GREEN_RST;
            row_blue_reg  <= dmm_pkg::ROW_BLUE_RST;
            tol_reg       <= dmm_pkg::TOL_RST;
        end
        else
        begin
            row_red_reg   <= row_red_next;
            row_green_reg <= row_green_next;
            row_blue_reg  <= row_blue_next;
            tol_reg       <= tol_next;
        end
    end

    // Check all nine coefficients against the identity within tolerance
    always_comb
    begin
        logic signed [dmm_pkg::DIFF_W-1:0] diff;
        logic        [dmm_pkg::DIFF_W-1:0] mag;
        rows[0] = row_red_reg;
        rows[1] = row_green_reg;
        rows[2] = row_blue_reg;
        ident   = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                diff = dmm_pkg::DIFF_W'(signed'(rows[i][j*dmm_pkg::DATA_W +: dmm_pkg::DATA_W]));
                if (i == j)
                begin
                    diff = diff - dmm_pkg::DIFF_W'(dmm_pkg::UNITY);
                end
                mag = diff[dmm_pkg::DIFF_W-1] ? dmm_pkg::DIFF_W'(-diff) : dmm_pkg::DIFF_W'(diff);
                if (mag > dmm_pkg::DIFF_W'(tol_reg))
                begin
                    ident = 1'b0;
                end
            end
        end
    end

    assign cfg.row_red   = row_red_reg;
    assign cfg.row_green = row_green_reg;
    assign cfg.row_blue  = row_blue_reg;
    assign cfg.bypass    = ident;

endmodule

// ===== rtl/core/dmm_mix_lane.sv =====
// One output channel of the mixer: three coefficient-by-density products,
// then sum, round, floor at zero and saturate. Depends on dmm_pkg.
module dmm_mix_lane (
    input  logic [dmm_pkg::ROW_W-1:0]     row,
    input  dmm_pkg::pix_in_t              pix,
    output logic [dmm_pkg::DATA_W-1:0]    mixed
);

    logic signed [dmm_pkg::PROD_W-1:0] prod [3];
    logic signed [dmm_pkg::DATA_W-1:0] dens [3];
    logic signed [dmm_pkg::ACC_W-1:0]  acc;
    logic signed [dmm_pkg::ACC_W-1:0]  scaled;

    // Form the three coefficient-by-density products
    always_comb
    begin
        dens[0] = pix.density_red;
        dens[1] = pix.density_green;
        dens[2] = pix.density_blue;
        for (int j = 0; j < 3; j++)
        begin
            prod[j] = signed'(row[j*dmm_pkg::DATA_W +: dmm_pkg::DATA_W]) * dens[j];
        end
    end

    // Sum, round to nearest, floor at zero and saturate
    always_comb
    begin
        acc = dmm_pkg::ACC_W'(prod[0]) + dmm_pkg::ACC_W'(prod[1])
            + dmm_pkg::ACC_W'(prod[2]) + dmm_pkg::ROUND_HALF;
        scaled = acc >>> dmm_pkg::FRAC_BITS;
        if (acc[dmm_pkg::ACC_W-1])
        begin
            mixed = '0;
        end
        else if (scaled > dmm_pkg::SAT_LIMIT)
        begin
            mixed = dmm_pkg::SAT_MAX;
        end
        else
        begin
            mixed = scaled[dmm_pkg::DATA_W-1:0];
        end
    end

endmodule

// ===== rtl/core/density_matrix_mix_floor.sv =====
// Top level of the 3x3 density matrix mixer with floor and identity bypass.
// Depends on dmm_pkg, dmm_cfg_regs and dmm_mix_lane.
//
//  channel | signals                        | transaction
//  --------+--------------------------------+------------------------------
//  in      | in_valid, in_ready, in_data    | one pixel of three densities
//  out     | out_valid, out_ready, out_data | one mixed pixel
//  cfg     | cfg_we, cfg_index, cfg_data    | one register write, no wait
//
// One pixel per clock sustained while out_ready stays high. Each pixel is held in the
// input register, then in the result register that drives out_valid. The three 16x16
// products of each lane, the sum, rounding and clamp all sit between the two.
// Reset clears both valid flags and loads the identity matrix, tolerance 4.
// A stall on out_ready holds the result; in_ready stays high while the input
// register is empty or can hand its pixel on in the same cycle.
module density_matrix_mix_floor (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  dmm_pkg::pix_in_t                in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output dmm_pkg::pix_out_t               out_data,
    input  logic                            cfg_we,
    input  logic [dmm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dmm_pkg::CFG_DATA_W-1:0]  cfg_data
);

    dmm_pkg::mix_cfg_t cfg;

    logic              a_valid_reg, a_valid_next;
    dmm_pkg::pix_in_t  a_pix_reg;
    logic              c_valid_reg, c_valid_next;
    dmm_pkg::pix_out_t c_pix_reg, c_pix_next;

    logic              a_load, c_load;
    logic              a_free, c_free;
    logic [dmm_pkg::DATA_W-1:0] mix_red, mix_green, mix_blue;

    dmm_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Stage flow: each register loads when the one ahead of it frees up
    always_comb
    begin
        c_free = !c_valid_reg || out_ready;
        a_free = !a_valid_reg || c_free;
        a_load = in_valid && a_free;
        c_load = a_valid_reg && c_free;

        a_valid_next = a_load ? 1'b1 : (c_load ? 1'b0 : a_valid_reg);
        c_valid_next = c_load ? 1'b1 : (out_ready ? 1'b0 : c_valid_reg);
    end

    assign in_ready = a_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            c_valid_reg <= c_valid_next;
        end
    end

    // Capture the input pixel
    always_ff @(posedge clk)
    begin
        if (a_load)
        begin
            a_pix_reg <= in_data;
        end
    end

    dmm_mix_lane u_lane_red (
        .row   (cfg.row_red),
        .pix   (a_pix_reg),
        .mixed (mix_red)
    );

    dmm_mix_lane u_lane_green (
        .row   (cfg.row_green),
        .pix   (a_pix_reg),
        .mixed (mix_green)
    );

    dmm_mix_lane u_lane_blue (
        .row   (cfg.row_blue),
        .pix   (a_pix_reg),
        .mixed (mix_blue)
    );

    // Select pass-through or mixed result
    always_comb
    begin
        if (cfg.bypass)
        begin
            c_pix_next.out_red   = a_pix_reg.density_red;
            c_pix_next.out_green = a_pix_reg.density_green;
            c_pix_next.out_blue  = a_pix_reg.density_blue;
        end
        else
        begin
            c_pix_next.out_red   = signed'(mix_red);
            c_pix_next.out_green = signed'(mix_green);
            c_pix_next.out_blue  = signed'(mix_blue);
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_load)
        begin
            c_pix_reg <= c_pix_next;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_data  = c_pix_reg;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for density_matrix_mix_floor: predicts each mixed pixel
// from its own copy of the coefficient registers and compares it with the block's output.
// Depends on dmm_pkg and the RTL under rtl/core.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dmm_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int RAND_PHASES = 29;
    localparam int PHASE_PIXELS = 56;

    // Expected-pixel store with its own register copy and mixing predictor
    class mix_scoreboard;
        logic [ROW_W-1:0] rows [3];
        logic [TOL_W-1:0] tol;
        pix_out_t         expected_q[$];
        int               errors;
        int               checked;
        int               noted;
        int               bypassed;

        function new();
            rows[0] = ROW_RED_RST;
            rows[1] = ROW_GREEN_RST;
            rows[2] = ROW_BLUE_RST;
            tol = TOL_RST;
            errors = 0;
            checked = 0;
            noted = 0;
            bypassed = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_ROW_RED:   rows[0] = data;
                CFG_ROW_GREEN: rows[1] = data;
                CFG_ROW_BLUE:  rows[2] = data;
                CFG_TOLERANCE: tol = data[TOL_W-1:0];
                default: ;
            endcase
        endfunction

        // Every coefficient must sit within the tolerance of the identity matrix
        function bit is_identity();
            logic signed [DATA_W-1:0] c;
            int diff;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    c = rows[i][DATA_W*j +: DATA_W];
                    diff = int'(c) - ((i == j) ? (1 << FRAC_BITS) : 0);
                    if (diff < 0)
                        diff = -diff;
                    if (diff > int'(tol))
                        return 0;
                end
            end
            return 1;
        endfunction

        function pix_out_t predict_mix(pix_in_t p);
            pix_out_t                 r;
            logic signed [DATA_W-1:0] d [3];
            logic signed [DATA_W-1:0] c;
            logic [DATA_W-1:0]        lane [3];
            longint                   acc;
            d[0] = p.density_red;
            d[1] = p.density_green;
            d[2] = p.density_blue;
            if (is_identity()) begin
                bypassed++;
                r.out_red = p.density_red;
                r.out_green = p.density_green;
                r.out_blue = p.density_blue;
                return r;
            end
            // Exact dot product, round half up, floor at zero, saturate at the top
            for (int i = 0; i < 3; i++) begin
                acc = 0;
                for (int j = 0; j < 3; j++) begin
                    c = rows[i][DATA_W*j +: DATA_W];
                    acc += longint'(c) * longint'(d[j]);
                end
                acc += longint'(1) << (FRAC_BITS - 1);
                if (acc < 0)
                    lane[i] = '0;
                else begin
                    acc = acc >>> FRAC_BITS;
                    lane[i] = (acc > 32767) ? 16'h7FFF : acc[DATA_W-1:0];
                end
            end
            r.out_red = lane[0];
            r.out_green = lane[1];
            r.out_blue = lane[2];
            return r;
        endfunction

        function void note_pixel(pix_in_t p);
            noted++;
            expected_q.push_back(predict_mix(p));
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10)
                $display("ERROR %0d: %s", errors, msg);
        endfunction

        function void check_pixel(pix_out_t got);
            pix_out_t want;
            checked++;
            if (expected_q.size() == 0) begin
                flag($sformatf("result (%0d, %0d, %0d) with no pixel pending",
                               got.out_red, got.out_green, got.out_blue));
                return;
            end
            want = expected_q.pop_front();
            if (got.out_red !== want.out_red)
                flag($sformatf("out_red expected %0d got %0d", want.out_red, got.out_red));
            if (got.out_green !== want.out_green)
                flag($sformatf("out_green expected %0d got %0d",
                               want.out_green, got.out_green));
            if (got.out_blue !== want.out_blue)
                flag($sformatf("out_blue expected %0d got %0d", want.out_blue, got.out_blue));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void close_out();
            if (expected_q.size() != 0)
                flag($sformatf("%0d expected pixels never came out", expected_q.size()));
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    pix_in_t               in_data;
    logic                  out_valid;
    logic                  out_ready;
    pix_out_t              out_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    mix_scoreboard sb = new();

    int               send_idle_pct;
    int               recv_idle_pct;
    int               n_configs;
    int               cycles;
    logic [ROW_W-1:0] cfg_rows [3];

    density_matrix_mix_floor dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Stall the output side at random
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Record every transaction on the pixel input and output channels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_pixel(in_data);
            if (out_valid && out_ready)
                sb.check_pixel(out_data);
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d pixels outstanding", cycles, sb.pending());
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [ROW_W-1:0] row_of(logic [15:0] wr, logic [15:0] wg,
                                                 logic [15:0] wb);
        return {wb, wg, wr};
    endfunction

    function automatic logic [15:0] rand_density();
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(4))
                    0: return 16'h7FFF;
                    1: return 16'h8000;
                    2: return 16'hFFFF;
                    3: return 16'h0001;
                    default: return 16'h0000;
                endcase
            end
            1, 2: return 16'($urandom_range(0, 8191) - 4096);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] near_coef(bit diag, int tol_val, bit outside);
        int off;
        if (outside)
            off = tol_val + 1 + $urandom_range(0, 3);
        else
            off = $urandom_range(0, tol_val);
        if ($urandom_range(1))
            off = -off;
        return 16'((diag ? (1 << FRAC_BITS) : 0) + off);
    endfunction

    function automatic logic [15:0] extreme_coef();
        case ($urandom_range(4))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'h1000;
            default: return 16'hF000;
        endcase
    endfunction

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        sb.write_reg(idx, data);
        @(posedge clk);
    endtask

    // Write all registers, junk in the unused tolerance bits, then poke an unmapped index
    task automatic load_config(input logic [TOL_W-1:0] tol_val);
        logic [CFG_DATA_W-1:0] tol_word;
        logic [CFG_IDX_W-1:0]  junk_idx;
        tol_word = 48'({$urandom, $urandom});
        tol_word[TOL_W-1:0] = tol_val;
        junk_idx = CFG_TOLERANCE + 3'($urandom_range(1, 4));
        put_reg(CFG_ROW_RED, cfg_rows[0]);
        put_reg(CFG_ROW_GREEN, cfg_rows[1]);
        put_reg(CFG_ROW_BLUE, cfg_rows[2]);
        put_reg(CFG_TOLERANCE, tol_word);
        put_reg(junk_idx, 48'({$urandom, $urandom}));
        cfg_we <= 1'b0;
        n_configs++;
    endtask

    // Offer one pixel after a random gap; return at the edge that accepts it
    task automatic send_pixel(input pix_in_t p);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= p;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_rgb(input logic [15:0] r, input logic [15:0] g, input logic [15:0] b);
        pix_in_t p;
        p.density_red = r;
        p.density_green = g;
        p.density_blue = b;
        send_pixel(p);
    endtask

    // Drop valid and wait until every pixel in flight has come out
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int            kind;
        int            tol_val;
        int            oi;
        int            oj;
        bit            push_out;
        logic [15:0]   c;
        pix_in_t       p;

        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_data <= '0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_ROW_RED;
        cfg_data <= '0;
        send_idle_pct = 32;
        recv_idle_pct = 60;
        n_configs = 0;
        cycles = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset matrix is identity: pass everything through, negatives included
        send_rgb(16'h0000, 16'h0000, 16'h0000);
        send_rgb(16'h7FFF, 16'h8000, 16'hFFFF);
        send_rgb(16'h8000, 16'h7FFF, 16'h0001);
        send_rgb(16'h1234, 16'hFFFF, 16'h8000);
        settle();

        // Every coefficient exactly at the tolerance edge still bypasses
        cfg_rows[0] = row_of(16'd4196, 16'(-100), 16'(-100));
        cfg_rows[1] = row_of(16'(-100), 16'd4196, 16'(-100));
        cfg_rows[2] = row_of(16'd100, 16'd100, 16'd3996);
        load_config(12'd100);
        send_rgb(16'h8000, 16'h8000, 16'h8000);
        send_rgb(16'hFFFF, 16'h0000, 16'h7FFF);
        settle();

        // One step past the edge mixes, with the floor on negative sums
        cfg_rows[0] = row_of(16'd4197, 16'(-100), 16'(-100));
        load_config(12'd100);
        send_rgb(16'hF000, 16'h1000, 16'h1000);
        send_rgb(16'h7FFF, 16'h7FFF, 16'h7FFF);
        settle();

        // Zero tolerance: exact identity bypasses, one LSB off mixes
        cfg_rows[0] = ROW_RED_RST;
        cfg_rows[1] = ROW_GREEN_RST;
        cfg_rows[2] = ROW_BLUE_RST;
        load_config(12'd0);
        send_rgb(16'h8000, 16'h7FFF, 16'hFFFF);
        settle();
        cfg_rows[0] = row_of(16'h1000, 16'h0001, 16'h0000);
        load_config(12'd0);
        send_rgb(16'h8000, 16'h7FFF, 16'hFFFF);
        send_rgb(16'h0000, 16'h0000, 16'h0000);
        settle();

        // Largest positive coefficients: saturate, floor, smallest step
        for (int i = 0; i < 3; i++)
            cfg_rows[i] = row_of(16'h7FFF, 16'h7FFF, 16'h7FFF);
        load_config(12'd4095);
        send_rgb(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_rgb(16'h8000, 16'h8000, 16'h8000);
        send_rgb(16'h0001, 16'h0000, 16'h0000);
        settle();

        // Most negative coefficients
        for (int i = 0; i < 3; i++)
            cfg_rows[i] = row_of(16'h8000, 16'h8000, 16'h8000);
        load_config(12'd4095);
        send_rgb(16'h8000, 16'h8000, 16'h8000);
        send_rgb(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_rgb(16'hFFFF, 16'h0000, 16'h0000);
        settle();

        // Half-weight diagonal: rounding ties go up, negative ties land on zero
        cfg_rows[0] = row_of(16'h0800, 16'h0000, 16'h0000);
        cfg_rows[1] = row_of(16'h0000, 16'h0800, 16'h0000);
        cfg_rows[2] = row_of(16'h0000, 16'h0000, 16'h0800);
        load_config(12'd0);
        send_rgb(16'h0001, 16'h0003, 16'hFFFF);
        send_rgb(16'hFFFD, 16'h0005, 16'h7FFF);
        settle();

        // Random settings, each followed by a burst of random pixels
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            if (ph < RAND_PHASES / 3)
            begin
                send_idle_pct = 32;
                recv_idle_pct = 60;
            end
            else if (ph < 2 * RAND_PHASES / 3)
            begin
                send_idle_pct = 60;
                recv_idle_pct = 32;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            kind = $urandom_range(3);
            tol_val = $urandom_range(0, 4095);
            if (kind == 1)
            begin
                case ($urandom_range(3))
                    0: tol_val = 0;
                    1: tol_val = 4095;
                    default: tol_val = $urandom_range(0, 300);
                endcase
            end
            push_out = $urandom_range(1);
            oi = $urandom_range(2);
            oj = $urandom_range(2);
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    case (kind)
                        0: c = 16'($urandom);
                        1: c = near_coef(i == j, tol_val, push_out && i == oi && j == oj);
                        2: c = 16'($urandom_range(0, 16383) - 8192);
                        default: c = extreme_coef();
                    endcase
                    cfg_rows[i][DATA_W*j +: DATA_W] = c;
                end
            end
            load_config(TOL_W'(tol_val));

            for (int k = 0; k < PHASE_PIXELS; k++)
            begin
                p.density_red = rand_density();
                p.density_green = rand_density();
                p.density_blue = rand_density();
                send_pixel(p);
            end
            settle();
        end

        // Let any stray output surface before the verdict
        repeat (8) @(posedge clk);
        sb.close_out();

        $display("Ran %0d pixels through %0d register settings, %0d of them in identity bypass.",
                 sb.noted, n_configs, sb.bypassed);
        $display("Checked %0d output pixels with %0d errors.", sb.checked, sb.errors);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
